[sv/http_response_head_parser_top_macros.svh]
// Assertion macros used by the checker file of the response head parser.
`ifndef HTTP_RESPONSE_HEAD_PARSER_TOP_MACROS_SVH
`define HTTP_RESPONSE_HEAD_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hrhp checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define HRHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hrhp checker: next-cycle property failed");

`endif

[sv/hrhp_pkg.sv]
package hrhp_pkg;

  // Largest message size; byte offsets saturate one below it, and never above 16 bits.
  localparam int unsigned MAX_MESSAGE_BYTES = 65536;
  localparam int unsigned POS_LIMIT_INT =
    ((MAX_MESSAGE_BYTES - 1) > 65535) ? 65535 : (MAX_MESSAGE_BYTES - 1);
  localparam logic [15:0] POS_LIMIT = 16'(POS_LIMIT_INT);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2,
    PH_ERROR  = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    SS_H      = 4'd0,
    SS_T1     = 4'd1,
    SS_T2     = 4'd2,
    SS_P      = 4'd3,
    SS_SLASH  = 4'd4,
    SS_MAJOR  = 4'd5,
    SS_DOT    = 4'd6,
    SS_MINOR  = 4'd7,
    SS_SEP1   = 4'd8,
    SS_CODE0  = 4'd9,
    SS_CODE1  = 4'd10,
    SS_CODE2  = 4'd11,
    SS_SEP2   = 4'd12,
    SS_REASON = 4'd13,
    SS_LF     = 4'd14,
    SS_FAILED = 4'd15
  } status_step_e;

  typedef enum logic [2:0] {
    HS_LINE_START = 3'd0,
    HS_NAME       = 3'd1,
    HS_VALUE_WAIT = 3'd2,
    HS_VALUE      = 3'd3,
    HS_TRAIL      = 3'd4,
    HS_CR         = 3'd5,
    HS_BLANK_CR   = 3'd6
  } header_step_e;

  typedef enum logic [2:0] {
    EV_MORE       = 3'd0,
    EV_STATUS     = 3'd1,
    EV_LINE       = 3'd2,
    EV_HEAD       = 3'd3,
    EV_STATUS_ERR = 3'd4,
    EV_HDR_ERR    = 3'd5,
    EV_BODY       = 3'd6
  } event_e;

  typedef struct packed {
    event_e      event_res;
    logic [3:0]  version_major;
    logic [3:0]  version_minor;
    logic [9:0]  status_value;
    logic        line_valid;
    logic [15:0] name_offset;
    logic [15:0] name_length;
    logic [15:0] value_offset;
    logic [15:0] value_length;
    logic [15:0] byte_position;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_DASH) || (c == CH_UNDER);
  endfunction

  // Expected byte for each step of the "HTTP/" prefix.
  function automatic logic [7:0] lead_char(input status_step_e s);
    logic [7:0] c;
    case (s)
      SS_H:    c = CH_H;
      SS_T1:   c = CH_T;
      SS_T2:   c = CH_T;
      SS_P:    c = CH_P;
      default: c = CH_SLASH;
    endcase
    return c;
  endfunction

endpackage

[sv/http_response_head_parser_top.sv]
// Output: a result transfer is offered in the cycle after its input byte is accepted when the
// result register is free; a result that meets a held result register waits in the skid stage
// and is offered in the cycle after the held one leaves.
// Throughput: one byte per cycle while in_stall_o is low; the per-byte state update is one pass
// of combinational logic from the parser state registers to the result register.
// Reset: rst_ni is asynchronous and active low; it returns the parser to the start
// of the status line and empties the result register and the skid stage.
module http_response_head_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        message_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [3:0]  version_major_o,
  output logic [3:0]  version_minor_o,
  output logic [9:0]  status_value_o,
  output logic        line_valid_o,
  output logic [15:0] name_offset_o,
  output logic [15:0] name_length_o,
  output logic [15:0] value_offset_o,
  output logic [15:0] value_length_o,
  output logic [15:0] byte_position_o
);
  import hrhp_pkg::*;

  // Parser state. Each register has a "base" view: the stored value, or its
  // reset value when the accepted byte carries message_start.
  phase_e       phase_q, phase_d, phase_b;
  status_step_e sstep_q, sstep_d, sstep_b;
  header_step_e hstep_q, hstep_d, hstep_b;
  logic [3:0]   major_q, major_d, major_b;
  logic [3:0]   minor_q, minor_d, minor_b;
  logic [9:0]   code_q, code_d, code_b;
  logic [15:0]  pos_q, pos_d, pos_b;
  logic [15:0]  nbeg_q, nbeg_d, nbeg_b;
  logic [15:0]  nfin_q, nfin_d, nfin_b;
  logic [15:0]  vbeg_q, vbeg_d, vbeg_b;
  logic [15:0]  vfin_q, vfin_d, vfin_b;
  logic [15:0]  rbeg_q, rbeg_d, rbeg_b;
  logic         name_ok_q, name_ok_d, name_ok_b;

  logic [13:0]  code_sum;
  logic         status_fail;
  logic         status_done;
  logic         line_end;
  result_t      res;

  // Output side: a result register and one skid stage behind it.
  result_t      out_q, out_d;
  result_t      skid_q, skid_d;
  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  logic         in_accept;
  logic         out_free;

  // The skid stage is only ever filled while the result register is held, so
  // the input can keep taking bytes until both are full.
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    phase_b   = message_start_i ? PH_STATUS     : phase_q;
    sstep_b   = message_start_i ? SS_H          : sstep_q;
    hstep_b   = message_start_i ? HS_LINE_START : hstep_q;
    major_b   = message_start_i ? 4'd0  : major_q;
    minor_b   = message_start_i ? 4'd0  : minor_q;
    code_b    = message_start_i ? 10'd0 : code_q;
    pos_b     = message_start_i ? 16'd0 : pos_q;
    nbeg_b    = message_start_i ? 16'd0 : nbeg_q;
    nfin_b    = message_start_i ? 16'd0 : nfin_q;
    vbeg_b    = message_start_i ? 16'd0 : vbeg_q;
    vfin_b    = message_start_i ? 16'd0 : vfin_q;
    rbeg_b    = message_start_i ? 16'd0 : rbeg_q;
    name_ok_b = message_start_i ? 1'b1  : name_ok_q;

    phase_d   = phase_b;
    sstep_d   = sstep_b;
    hstep_d   = hstep_b;
    major_d   = major_b;
    minor_d   = minor_b;
    code_d    = code_b;
    nbeg_d    = nbeg_b;
    nfin_d    = nfin_b;
    vbeg_d    = vbeg_b;
    vfin_d    = vfin_b;
    rbeg_d    = rbeg_b;
    name_ok_d = name_ok_b;
    pos_d     = (pos_b < POS_LIMIT) ? pos_b + 16'd1 : pos_b;

    // code * 10 + digit, kept to ten bits.
    code_sum    = {1'b0, code_b, 3'b000} + {3'b000, code_b, 1'b0} +
                  {10'd0, data_byte_i[3:0]};
    status_fail = 1'b0;
    status_done = 1'b0;
    line_end    = 1'b0;

    res               = '0;
    res.event_res     = EV_MORE;
    res.byte_position = pos_b;

    case (phase_b)
      PH_STATUS: begin
        case (sstep_b)
          SS_H, SS_T1, SS_T2, SS_P, SS_SLASH: begin
            if (data_byte_i == lead_char(sstep_b)) begin
              sstep_d = status_step_e'(4'(sstep_b + 4'd1));
            end else begin
              status_fail = 1'b1;
            end
          end
          SS_MAJOR, SS_MINOR: begin
            if (is_digit(data_byte_i)) begin
              if (sstep_b == SS_MAJOR) begin
                major_d = data_byte_i[3:0];
              end else begin
                minor_d = data_byte_i[3:0];
              end
              sstep_d = status_step_e'(4'(sstep_b + 4'd1));
            end else begin
              status_fail = 1'b1;
            end
          end
          SS_DOT: begin
            if (data_byte_i == CH_DOT) begin
              sstep_d = SS_MINOR;
            end else begin
              status_fail = 1'b1;
            end
          end
          SS_SEP1: begin
            if (data_byte_i >= CH_SPACE) begin
              sstep_d = SS_CODE0;
            end else begin
              status_fail = 1'b1;
            end
          end
          SS_CODE0, SS_CODE1, SS_CODE2: begin
            if (is_digit(data_byte_i)) begin
              code_d  = code_sum[9:0];
              sstep_d = status_step_e'(4'(sstep_b + 4'd1));
            end else begin
              status_fail = 1'b1;
            end
          end
          SS_SEP2: begin
            if (data_byte_i >= CH_SPACE) begin
              sstep_d = SS_REASON;
              rbeg_d  = (pos_b < POS_LIMIT) ? pos_b + 16'd1 : pos_b;
            end else begin
              status_fail = 1'b1;
            end
          end
          SS_REASON: begin
            if (data_byte_i == CH_CR) begin
              vfin_d  = pos_b;
              sstep_d = SS_LF;
            end else if (data_byte_i == CH_LF) begin
              vfin_d      = pos_b;
              status_done = 1'b1;
            end
          end
          SS_LF: begin
            if (data_byte_i == CH_LF) begin
              status_done = 1'b1;
            end else begin
              status_fail = 1'b1;
            end
          end
          default: begin
            status_fail = 1'b1;
          end
        endcase
        if (status_fail) begin
          phase_d = PH_ERROR;
          sstep_d = SS_FAILED;
        end
        if (status_done) begin
          phase_d          = PH_HEADER;
          hstep_d          = HS_LINE_START;
          res.event_res    = EV_STATUS;
          res.value_offset = rbeg_d;
          res.value_length = vfin_d - rbeg_d;
        end
      end

      PH_HEADER: begin
        case (hstep_b)
          HS_LINE_START: begin
            nbeg_d = pos_b;
            if (data_byte_i == CH_CR) begin
              hstep_d = HS_BLANK_CR;
            end else if (data_byte_i == CH_LF) begin
              phase_d       = PH_BODY;
              res.event_res = EV_HEAD;
            end else if (data_byte_i == CH_NUL) begin
              phase_d = PH_ERROR;
            end else begin
              hstep_d = HS_NAME;
              if (!is_name_char(data_byte_i)) begin
                name_ok_d = 1'b0;
              end
            end
          end
          HS_NAME: begin
            if (is_name_char(data_byte_i)) begin
              hstep_d = HS_NAME;
            end else if (data_byte_i == CH_COLON) begin
              nfin_d  = pos_b;
              hstep_d = HS_VALUE_WAIT;
            end else if ((data_byte_i == CH_CR) || (data_byte_i == CH_LF)) begin
              // A line without a colon is all name, with an empty value at its end.
              nfin_d = pos_b;
              vbeg_d = pos_b;
              vfin_d = pos_b;
              if (data_byte_i == CH_CR) begin
                hstep_d = HS_CR;
              end else begin
                line_end = 1'b1;
              end
            end else if (data_byte_i == CH_NUL) begin
              phase_d = PH_ERROR;
            end else begin
              name_ok_d = 1'b0;
            end
          end
          HS_VALUE_WAIT: begin
            if (data_byte_i == CH_SPACE) begin
              hstep_d = HS_VALUE_WAIT;
            end else if ((data_byte_i == CH_CR) || (data_byte_i == CH_LF)) begin
              vbeg_d = pos_b;
              vfin_d = pos_b;
              if (data_byte_i == CH_CR) begin
                hstep_d = HS_CR;
              end else begin
                line_end = 1'b1;
              end
            end else if (data_byte_i == CH_NUL) begin
              phase_d = PH_ERROR;
            end else begin
              vbeg_d  = pos_b;
              hstep_d = HS_VALUE;
            end
          end
          HS_VALUE: begin
            // The value end is marked at the first of any trailing spaces.
            if (data_byte_i == CH_SPACE) begin
              vfin_d  = pos_b;
              hstep_d = HS_TRAIL;
            end else if (data_byte_i == CH_CR) begin
              vfin_d  = pos_b;
              hstep_d = HS_CR;
            end else if (data_byte_i == CH_LF) begin
              vfin_d   = pos_b;
              line_end = 1'b1;
            end else if (data_byte_i == CH_NUL) begin
              phase_d = PH_ERROR;
            end
          end
          HS_TRAIL: begin
            if (data_byte_i == CH_SPACE) begin
              hstep_d = HS_TRAIL;
            end else if (data_byte_i == CH_CR) begin
              hstep_d = HS_CR;
            end else if (data_byte_i == CH_LF) begin
              line_end = 1'b1;
            end else if (data_byte_i == CH_NUL) begin
              phase_d = PH_ERROR;
            end else begin
              hstep_d = HS_VALUE;
            end
          end
          HS_CR: begin
            // Extra CR bytes before the LF are skipped.
            if (data_byte_i == CH_LF) begin
              line_end = 1'b1;
            end else if (data_byte_i != CH_CR) begin
              phase_d = PH_ERROR;
            end
          end
          default: begin
            // CR of the blank line: only LF may follow.
            if (data_byte_i == CH_LF) begin
              phase_d       = PH_BODY;
              res.event_res = EV_HEAD;
            end else begin
              phase_d = PH_ERROR;
            end
          end
        endcase
        if (line_end) begin
          res.event_res    = EV_LINE;
          res.line_valid   = name_ok_d;
          res.name_offset  = nbeg_d;
          res.name_length  = nfin_d - nbeg_d;
          res.value_offset = vbeg_d;
          res.value_length = vfin_d - vbeg_d;
          name_ok_d        = 1'b1;
          hstep_d          = HS_LINE_START;
        end
      end

      PH_BODY: begin
        res.event_res = EV_BODY;
      end

      default: begin
        res.event_res = EV_MORE;
      end
    endcase

    // Errors stick; the kind is told apart by the status step.
    if (phase_d == PH_ERROR) begin
      res.event_res = (sstep_d == SS_FAILED) ? EV_STATUS_ERR : EV_HDR_ERR;
    end

    res.version_major = major_d;
    res.version_minor = minor_d;
    res.status_value  = code_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_STATUS;
      sstep_q   <= SS_H;
      hstep_q   <= HS_LINE_START;
      major_q   <= 4'd0;
      minor_q   <= 4'd0;
      code_q    <= 10'd0;
      pos_q     <= 16'd0;
      nbeg_q    <= 16'd0;
      nfin_q    <= 16'd0;
      vbeg_q    <= 16'd0;
      vfin_q    <= 16'd0;
      rbeg_q    <= 16'd0;
      name_ok_q <= 1'b1;
    end else if (in_accept) begin
      phase_q   <= phase_d;
      sstep_q   <= sstep_d;
      hstep_q   <= hstep_d;
      major_q   <= major_d;
      minor_q   <= minor_d;
      code_q    <= code_d;
      pos_q     <= pos_d;
      nbeg_q    <= nbeg_d;
      nfin_q    <= nfin_d;
      vbeg_q    <= vbeg_d;
      vfin_q    <= vfin_d;
      rbeg_q    <= rbeg_d;
      name_ok_q <= name_ok_d;
    end
  end

  // Result register and skid stage steering. When the result register can
  // move, it takes the skid entry first, else the fresh result; a fresh
  // result that finds the register held goes into the skid stage.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = in_accept;
      end
    end else if (in_accept) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = out_q.event_res;
  assign version_major_o = out_q.version_major;
  assign version_minor_o = out_q.version_minor;
  assign status_value_o  = out_q.status_value;
  assign line_valid_o    = out_q.line_valid;
  assign name_offset_o   = out_q.name_offset;
  assign name_length_o   = out_q.name_length;
  assign value_offset_o  = out_q.value_offset;
  assign value_length_o  = out_q.value_length;
  assign byte_position_o = out_q.byte_position;

endmodule

[sv/hrhp_checker.sv]
`include "http_response_head_parser_top_macros.svh"

module hrhp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  event_res_o,
  input logic        line_valid_o,
  input logic [15:0] name_offset_o,
  input logic [15:0] name_length_o,
  input logic [15:0] value_offset_o,
  input logic [15:0] value_length_o,
  input logic [15:0] byte_position_o
);
  import hrhp_pkg::*;

  // A held result stays valid and keeps its event and byte position.
  `HRHP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(event_res_o) && $stable(byte_position_o))

  // The input only stalls when a result is already waiting.
  `HRHP_ASSERT_NOW(a_stall_needs_result, clk_i, rst_ni, in_stall_o, out_valid_o)

  // Name fields are only filled on a header line result.
  `HRHP_ASSERT_NOW(a_name_only_on_line, clk_i, rst_ni,
    out_valid_o && (event_res_o != EV_LINE),
    !line_valid_o && (name_offset_o == 16'd0) && (name_length_o == 16'd0))

  // Value fields are only filled on a status or header line result.
  `HRHP_ASSERT_NOW(a_value_only_on_report, clk_i, rst_ni,
    out_valid_o && (event_res_o != EV_LINE) && (event_res_o != EV_STATUS),
    (value_offset_o == 16'd0) && (value_length_o == 16'd0))

endmodule

bind http_response_head_parser_top hrhp_checker u_hrhp_checker (.*);
